[hw/rtl/cron_next_match_time_macros.svh]
// Assertion macros shared by the checker of the schedule block.
`ifndef CRON_NEXT_MATCH_TIME_MACROS_SVH
`define CRON_NEXT_MATCH_TIME_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CNMT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CNMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[hw/rtl/cnmt_pkg.sv]
// Shared types, constants and calendar functions of the schedule block.
package cnmt_pkg;

    localparam int MAX_SEARCH_YEARS_DEF = 32;
    localparam logic [12:0] BASE_YEAR = 13'd2000;
    localparam logic [12:0] LAST_YEAR = 13'd4095;
    // Leap days counted up to and including 1999.
    localparam logic [13:0] LEAPS_1999 = 14'd484;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_WSUM,
        ST_WMUL,
        ST_WMOD,
        ST_BUMP,
        ST_SKIP,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [12:0] year;
        logic [3:0]  mon;
        logic [4:0]  mday;
        logic [2:0]  wday;
    } date_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] idx;
    } find_t;

    // Quotient by 100 through a reciprocal; exact for all 13-bit values.
    function automatic logic [6:0] div100(input logic [12:0] y);
        logic [25:0] p;
        p = 26'(y) * 26'd5243;
        return p[25:19];
    endfunction

    function automatic logic is_leap(input logic [12:0] y);
        logic [6:0]  q;
        logic [12:0] back;
        q    = div100(y);
        back = 13'(q) * 13'd100;
        return (y[1:0] == 2'd0) && ((back != y) || (q[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [12:0] y, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1: len = is_leap(y) ? 5'd29 : 5'd28;
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m, ignoring the leap day.
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd0:  c = 9'd0;
            4'd1:  c = 9'd31;
            4'd2:  c = 9'd59;
            4'd3:  c = 9'd90;
            4'd4:  c = 9'd120;
            4'd5:  c = 9'd151;
            4'd6:  c = 9'd181;
            4'd7:  c = 9'd212;
            4'd8:  c = 9'd243;
            4'd9:  c = 9'd273;
            4'd10: c = 9'd304;
            default: c = 9'd334;
        endcase
        return c;
    endfunction

    // Lowest set bit of a 60-bit mask at or above start.
    function automatic find_t first_set60(input logic [59:0] mask, input logic [6:0] start);
        find_t r;
        r = '0;
        for (int i = 59; i >= 0; i--) begin
            if (mask[i] && (7'(i) >= start)) begin
                r.hit = 1'b1;
                r.idx = 6'(i);
            end
        end
        return r;
    endfunction

    // Lowest set bit of a 24-bit mask at or above start.
    function automatic find_t first_set24(input logic [23:0] mask, input logic [4:0] start);
        find_t r;
        r = '0;
        for (int i = 23; i >= 0; i--) begin
            if (mask[i] && (5'(i) >= start)) begin
                r.hit = 1'b1;
                r.idx = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/cnmt_calendar.sv]
// Day advance unit: moves a date and its weekday on by one day.
module cnmt_calendar (
    input  cnmt_pkg::date_t cur,
    output cnmt_pkg::date_t nxt
);
    import cnmt_pkg::*;

    logic [4:0] len;
    logic [5:0] mday_inc;

    always_comb
    begin
        len      = month_len(cur.year, cur.mon);
        mday_inc = 6'(cur.mday) + 6'd1;
        nxt      = cur;
        nxt.wday = (cur.wday == 3'd6) ? 3'd0 : cur.wday + 3'd1;
        if (mday_inc > 6'(len))
        begin
            nxt.mday = 5'd1;
            if (cur.mon >= 4'd11)
            begin
                nxt.mon  = 4'd0;
                nxt.year = cur.year + 13'd1;
            end
            else
            begin
                nxt.mon = cur.mon + 4'd1;
            end
        end
        else
        begin
            nxt.mday = mday_inc[4:0];
        end
    end

endmodule

[hw/rtl/cron_next_match_time.sv]
// Top level of the schedule block: finds the next minute matching a calendar schedule.
//
//  Channel   Handshake           Words
//  request   start, busy         masks, day_and, skip_current_run, cur_* time
//  result    done (one cycle)    next_* time, next_weekday, found
//
// A request passes the set-up states (clamp, weekday sum, reciprocal multiply, remainder,
// one-minute bump), then steps hour by hour over a matching run when skipping, then day by
// day through the search, and ends in the done state that presents the result. The
// shared day-advance unit moves the date; skip and search both stop once the year leaves
// the search window of MAX_SEARCH_YEARS years.
// Reset clears the sequencer to idle; busy stays high until the done cycle has ended.
// The receiver cannot stall: done is high for exactly one cycle; the result words hold until the next request.
module cron_next_match_time #(
    parameter int MAX_SEARCH_YEARS = cnmt_pkg::MAX_SEARCH_YEARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [59:0] minute_mask,
    input  logic [23:0] hour_mask,
    input  logic [31:0] day_mask,
    input  logic [6:0]  weekday_mask,
    input  logic [11:0] month_mask,
    input  logic        day_and,
    input  logic        skip_current_run,
    input  logic [11:0] cur_year,
    input  logic [3:0]  cur_month,
    input  logic [4:0]  cur_mday,
    input  logic [4:0]  cur_hour,
    input  logic [5:0]  cur_minute,
    output logic [11:0] next_year,
    output logic [3:0]  next_month,
    output logic [4:0]  next_mday,
    output logic [4:0]  next_hour,
    output logic [5:0]  next_minute,
    output logic [2:0]  next_weekday,
    output logic        found
);
    import cnmt_pkg::*;

    state_t state_reg, state_next;

    logic [59:0] min_mask_reg;
    logic [23:0] hour_mask_reg;
    logic [31:0] day_mask_reg;
    logic [6:0]  wday_mask_reg;
    logic [11:0] mon_mask_reg;
    logic        day_and_reg;
    logic        skip_reg;
    logic [11:0] in_year_reg;
    logic [3:0]  in_mon_reg;
    logic [4:0]  in_mday_reg;
    logic [4:0]  in_hour_reg;
    logic [5:0]  in_min_reg;

    date_t       t_reg, t_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [12:0] limit_reg, limit_next;
    logic [6:0]  q100_reg, q100_next;
    logic [13:0] sum_reg, sum_next;
    logic [10:0] q7_reg, q7_next;
    logic        first_reg, first_next;

    logic [11:0] res_year_reg, res_year_next;
    logic [3:0]  res_mon_reg, res_mon_next;
    logic [4:0]  res_mday_reg, res_mday_next;
    logic [4:0]  res_hour_reg, res_hour_next;
    logic [5:0]  res_min_reg, res_min_next;
    logic [2:0]  res_wday_reg, res_wday_next;
    logic        found_reg, found_next;

    date_t t_adv;

    cnmt_calendar u_cal (
        .cur (t_reg),
        .nxt (t_adv)
    );

    // Helpers evaluated on the current search position.
    logic        in_window;
    logic        day_ok;
    logic        full_ok;
    logic [12:0] yc;
    logic [3:0]  mc;
    logic [4:0]  lc;
    logic [4:0]  dc;
    logic [12:0] ym1;
    logic [13:0] sum_w;
    logic [24:0] prod7;
    logic [13:0] back7;
    logic [4:0]  h0;
    logic [5:0]  m0;
    find_t       f_skip;
    find_t       f_min;
    find_t       f_hour;
    find_t       f_low;

    always_comb
    begin
        in_window = (t_reg.year < limit_reg) && (t_reg.year <= LAST_YEAR);
        day_ok = mon_mask_reg[t_reg.mon] &&
                 (day_and_reg ? (day_mask_reg[t_reg.mday] && wday_mask_reg[t_reg.wday])
                              : (day_mask_reg[t_reg.mday] || wday_mask_reg[t_reg.wday]));
        full_ok = min_mask_reg[min_reg] && hour_mask_reg[hour_reg] && day_ok;
        h0 = first_reg ? hour_reg : 5'd0;
        m0 = first_reg ? min_reg : 6'd0;
        f_skip = first_set60(~min_mask_reg, 7'(min_reg) + 7'd1);
        f_min  = first_set60(min_mask_reg, 7'(m0));
        f_hour = first_set24(hour_mask_reg, h0 + 5'd1);
        f_low  = first_set60(min_mask_reg, 7'd0);
    end

    always_comb
    begin
        state_next    = state_reg;
        t_next        = t_reg;
        hour_next     = hour_reg;
        min_next      = min_reg;
        limit_next    = limit_reg;
        q100_next     = q100_reg;
        sum_next      = sum_reg;
        q7_next       = q7_reg;
        first_next    = first_reg;
        res_year_next = res_year_reg;
        res_mon_next  = res_mon_reg;
        res_mday_next = res_mday_reg;
        res_hour_next = res_hour_reg;
        res_min_next  = res_min_reg;
        res_wday_next = res_wday_reg;
        found_next    = found_reg;

        yc = (in_year_reg < 12'd2000) ? BASE_YEAR : 13'(in_year_reg);
        mc = (in_mon_reg > 4'd11) ? 4'd11 : in_mon_reg;
        lc = month_len(yc, mc);
        dc = (in_mday_reg == 5'd0) ? 5'd1 : ((in_mday_reg > lc) ? lc : in_mday_reg);
        ym1 = t_reg.year - 13'd1;
        sum_w = 14'(t_reg.year - BASE_YEAR) + 14'(ym1[12:2]) - 14'(q100_reg)
              + 14'(q100_reg[6:2]) - LEAPS_1999 + 14'(cum_days(t_reg.mon))
              + 14'((t_reg.mon > 4'd1) && is_leap(t_reg.year))
              + 14'(t_reg.mday) + 14'd5;
        prod7 = 25'(sum_reg) * 25'd9363;
        back7 = 14'(q7_reg) * 14'd7;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                t_next.year = yc;
                t_next.mon  = mc;
                t_next.mday = dc;
                t_next.wday = 3'd0;
                hour_next   = (in_hour_reg > 5'd23) ? 5'd23 : in_hour_reg;
                min_next    = (in_min_reg > 6'd59) ? 6'd59 : in_min_reg;
                limit_next  = yc + 13'(MAX_SEARCH_YEARS);
                q100_next   = div100(yc - 13'd1);
                first_next  = 1'b1;
                state_next  = ST_WSUM;
            end
            ST_WSUM:
            begin
                sum_next   = sum_w;
                state_next = ST_WMUL;
            end
            ST_WMUL:
            begin
                // Quotient by seven through a reciprocal multiply.
                q7_next    = 11'(prod7[24:16]);
                state_next = ST_WMOD;
            end
            ST_WMOD:
            begin
                t_next.wday = 3'(sum_reg - back7);
                state_next  = ST_BUMP;
            end
            ST_BUMP:
            begin
                if (min_reg == 6'd59)
                begin
                    min_next = 6'd0;
                    if (hour_reg == 5'd23)
                    begin
                        hour_next = 5'd0;
                        t_next    = t_adv;
                    end
                    else
                    begin
                        hour_next = hour_reg + 5'd1;
                    end
                end
                else
                begin
                    min_next = min_reg + 6'd1;
                end
                found_next    = 1'b0;
                res_year_next = '0;
                res_mon_next  = '0;
                res_mday_next = '0;
                res_hour_next = '0;
                res_min_next  = '0;
                res_wday_next = '0;
                if ((min_mask_reg == '0) || (hour_mask_reg == '0))
                begin
                    state_next = ST_DONE;
                end
                else if (skip_reg)
                begin
                    state_next = ST_SKIP;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SKIP:
            begin
                if (!in_window || !full_ok)
                begin
                    state_next = ST_SEARCH;
                end
                else if (f_skip.hit)
                begin
                    min_next   = f_skip.idx;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    min_next = 6'd0;
                    if (hour_reg == 5'd23)
                    begin
                        hour_next = 5'd0;
                        t_next    = t_adv;
                    end
                    else
                    begin
                        hour_next = hour_reg + 5'd1;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (!in_window)
                begin
                    state_next = ST_DONE;
                end
                else if (day_ok && hour_mask_reg[h0] && f_min.hit)
                begin
                    found_next    = 1'b1;
                    res_year_next = t_reg.year[11:0];
                    res_mon_next  = t_reg.mon;
                    res_mday_next = t_reg.mday;
                    res_hour_next = h0;
                    res_min_next  = f_min.idx;
                    res_wday_next = t_reg.wday;
                    state_next    = ST_DONE;
                end
                else if (day_ok && f_hour.hit)
                begin
                    found_next    = 1'b1;
                    res_year_next = t_reg.year[11:0];
                    res_mon_next  = t_reg.mon;
                    res_mday_next = t_reg.mday;
                    res_hour_next = f_hour.idx[4:0];
                    res_min_next  = f_low.idx;
                    res_wday_next = t_reg.wday;
                    state_next    = ST_DONE;
                end
                else
                begin
                    t_next     = t_adv;
                    first_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            min_mask_reg  <= minute_mask;
            hour_mask_reg <= hour_mask;
            day_mask_reg  <= day_mask;
            wday_mask_reg <= weekday_mask;
            mon_mask_reg  <= month_mask;
            day_and_reg   <= day_and;
            skip_reg      <= skip_current_run;
            in_year_reg   <= cur_year;
            in_mon_reg    <= cur_month;
            in_mday_reg   <= cur_mday;
            in_hour_reg   <= cur_hour;
            in_min_reg    <= cur_minute;
        end
        t_reg        <= t_next;
        hour_reg     <= hour_next;
        min_reg      <= min_next;
        limit_reg    <= limit_next;
        q100_reg     <= q100_next;
        sum_reg      <= sum_next;
        q7_reg       <= q7_next;
        first_reg    <= first_next;
        res_year_reg <= res_year_next;
        res_mon_reg  <= res_mon_next;
        res_mday_reg <= res_mday_next;
        res_hour_reg <= res_hour_next;
        res_min_reg  <= res_min_next;
        res_wday_reg <= res_wday_next;
        found_reg    <= found_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign next_year    = res_year_reg;
    assign next_month   = res_mon_reg;
    assign next_mday    = res_mday_reg;
    assign next_hour    = res_hour_reg;
    assign next_minute  = res_min_reg;
    assign next_weekday = res_wday_reg;
    assign found        = found_reg;

endmodule

[hw/rtl/cnmt_checker.sv]
// Port-level checker of the schedule block and its bind.
`include "cron_next_match_time_macros.svh"

module cnmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [11:0] next_year,
    input logic [3:0]  next_month,
    input logic [4:0]  next_mday,
    input logic [4:0]  next_hour,
    input logic [5:0]  next_minute,
    input logic [2:0]  next_weekday,
    input logic        found
);
    `CNMT_ASSERT_NOW(a_done_busy, done, busy)
    `CNMT_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done)
    `CNMT_ASSERT_NEXT(a_done_ends, done, !busy && !done)
    `CNMT_ASSERT_NOW(a_miss_zero, done && !found, (next_minute == 6'd0) && (next_hour == 5'd0) && (next_mday == 5'd0) && (next_year == 12'd0))
    `CNMT_ASSERT_NOW(a_hit_range, done && found, (next_minute < 6'd60) && (next_hour < 5'd24) && (next_weekday < 3'd7) && (next_month < 4'd12))

endmodule

bind cron_next_match_time cnmt_checker u_cnmt_checker (.*);
